FILE: design/psab_pkg.sv
// psab_pkg: shared types and constants for the palette sprite alpha blitter.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package psab_pkg;

  // Surface clip limit and fixed field widths
  localparam int MAX_SURFACE_DIM = 4096;
  localparam int IDX_W           = 8;
  localparam int COLOR_W         = 32;
  localparam int POS_W           = 12;
  localparam int CFG_W           = 13;
  localparam int CFG_IDX_W       = 3;

  // Item queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input action codes
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_PIXEL   = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SURFACE_WIDTH  = 3'd0,
    CFG_SURFACE_HEIGHT = 3'd1,
    CFG_SPRITE_WIDTH   = 3'd2,
    CFG_SPRITE_HEIGHT  = 3'd3,
    CFG_DEST_LEFT      = 3'd4,
    CFG_DEST_TOP       = 3'd5
  } cfg_reg_t;

  // Classified item: a palette write (data = color) or a pixel (data = background)
  typedef struct packed {
    logic               is_pixel;
    logic [IDX_W-1:0]   idx;
    logic [COLOR_W-1:0] data;
    logic               vis;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic               last;
  } blit_item_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } fifo_stat_t;

endpackage

`default_nettype wire

FILE: design/psab_ram.sv
// psab_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module psab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/psab_front.sv
// psab_front: configuration registers, sprite column/row counters and clipping.
// Depends on psab_pkg.
`default_nettype none

module psab_front import psab_pkg::*; #(
  parameter int MAX_SPRITE_DIM = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  input  wire logic                 accept,
  input  wire logic                 action,
  input  wire logic [IDX_W-1:0]     color_index,
  input  wire logic [COLOR_W-1:0]   palette_color,
  input  wire logic [COLOR_W-1:0]   background,
  output blit_item_t                item
);

  localparam int CNT_W = (MAX_SPRITE_DIM > 1) ? $clog2(MAX_SPRITE_DIM) : 1;
  localparam int CMP_W = (CNT_W + 1 > 10) ? CNT_W + 1 : 10;
  localparam int SUM_W = (CNT_W + 2 > 14) ? CNT_W + 2 : 14;

  logic [CFG_W-1:0] surface_width_r, surface_height_r;
  logic [8:0]       sprite_width_r, sprite_height_r;
  logic [CFG_W-1:0] dest_left_r, dest_top_r;
  logic [CNT_W-1:0] col_r, row_r;
  logic [CNT_W-1:0] col_nxt, row_nxt;

  logic [CMP_W-1:0] sw_ext, sh_ext, sw_cl, sh_cl;
  logic             col_wrap, row_wrap;
  logic [SUM_W-1:0] x_s, y_s;
  logic [CFG_W-1:0] lim_x, lim_y;
  logic             vis;
  logic             is_pixel;

  assign is_pixel = (action == ACT_PIXEL);

  // Clamp sprite size to 1..MAX_SPRITE_DIM
  always_comb begin
    sw_ext = CMP_W'(sprite_width_r);
    sh_ext = CMP_W'(sprite_height_r);
    if (sw_ext == '0) begin
      sw_cl = CMP_W'(1);
    end else if (sw_ext > CMP_W'(MAX_SPRITE_DIM)) begin
      sw_cl = CMP_W'(MAX_SPRITE_DIM);
    end else begin
      sw_cl = sw_ext;
    end
    if (sh_ext == '0) begin
      sh_cl = CMP_W'(1);
    end else if (sh_ext > CMP_W'(MAX_SPRITE_DIM)) begin
      sh_cl = CMP_W'(MAX_SPRITE_DIM);
    end else begin
      sh_cl = sh_ext;
    end
  end

  // A counter at or past a shrunk size wraps on its next step
  assign col_wrap = (CMP_W'(col_r) + CMP_W'(1)) >= sw_cl;
  assign row_wrap = (CMP_W'(row_r) + CMP_W'(1)) >= sh_cl;

  always_comb begin
    col_nxt = col_wrap ? '0 : col_r + CNT_W'(1);
    row_nxt = row_r;
    if (col_wrap) begin
      row_nxt = row_wrap ? '0 : row_r + CNT_W'(1);
    end
  end

  // Destination position and clip
  assign x_s = {{(SUM_W-CFG_W){dest_left_r[CFG_W-1]}}, dest_left_r} + SUM_W'(col_r);
  assign y_s = {{(SUM_W-CFG_W){dest_top_r[CFG_W-1]}}, dest_top_r} + SUM_W'(row_r);

  assign lim_x = (surface_width_r > CFG_W'(MAX_SURFACE_DIM)) ?
                 CFG_W'(MAX_SURFACE_DIM) : surface_width_r;
  assign lim_y = (surface_height_r > CFG_W'(MAX_SURFACE_DIM)) ?
                 CFG_W'(MAX_SURFACE_DIM) : surface_height_r;

  assign vis = !x_s[SUM_W-1] && !y_s[SUM_W-1] &&
               (x_s[SUM_W-2:0] < (SUM_W-1)'(lim_x)) &&
               (y_s[SUM_W-2:0] < (SUM_W-1)'(lim_y));

  always_comb begin
    item.is_pixel = is_pixel;
    item.idx      = color_index;
    item.data     = is_pixel ? background : palette_color;
    item.vis      = vis;
    item.x        = vis ? x_s[POS_W-1:0] : '0;
    item.y        = vis ? y_s[POS_W-1:0] : '0;
    item.last     = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surface_width_r  <= CFG_W'(640);
      surface_height_r <= CFG_W'(480);
      sprite_width_r   <= 9'd8;
      sprite_height_r  <= 9'd8;
      dest_left_r      <= '0;
      dest_top_r       <= '0;
      col_r            <= '0;
      row_r            <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SURFACE_WIDTH:  surface_width_r  <= cfg_wdata;
          CFG_SURFACE_HEIGHT: surface_height_r <= cfg_wdata;
          CFG_SPRITE_WIDTH:   sprite_width_r   <= cfg_wdata[8:0];
          CFG_SPRITE_HEIGHT:  sprite_height_r  <= cfg_wdata[8:0];
          CFG_DEST_LEFT:      dest_left_r      <= cfg_wdata;
          CFG_DEST_TOP:       dest_top_r       <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept && is_pixel) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/psab_fifo.sv
// psab_fifo: short item queue between the front and the back.
// Depends on psab_pkg.
`default_nettype none

module psab_fifo import psab_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire blit_item_t push_item,
  input  wire logic       pop,
  output blit_item_t      pop_item,
  output fifo_stat_t      stat
);

  blit_item_t        mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item   = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign stat.count = count_r;

endmodule

`default_nettype wire

FILE: design/psab_back.sv
// psab_back: palette memory, lookup and alpha blend pipeline with output register.
// Depends on psab_pkg and psab_ram.
`default_nettype none

module psab_back import psab_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_valid,
  input  wire blit_item_t         q_item,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_vis,
  output logic [POS_W-1:0]        out_x,
  output logic [POS_W-1:0]        out_y,
  output logic [COLOR_W-1:0]      out_blended,
  output logic                    out_last
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  typedef struct packed {
    logic               vis;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic               last;
  } pix_meta_t;

  logic               en;
  logic               in_range;
  logic [COLOR_W-1:0] ram_rdata;

  logic               s1_valid_r;
  pix_meta_t          s1_meta_r;
  logic [COLOR_W-1:0] s1_back_r;
  logic               s1_inr_r;

  logic               s2_valid_r;
  pix_meta_t          s2_meta_r;
  logic [7:0]         s2_alpha_r;
  logic [2:0][15:0]   s2_sum_r;
  logic [2:0][15:0]   sum_c;
  logic [COLOR_W-1:0] top;

  logic               s3_valid_r;
  pix_meta_t          s3_meta_r;
  logic [COLOR_W-1:0] s3_blended_r;
  logic [2:0][7:0]    quo_c;

  // Whole pipeline moves unless the output register is held
  assign en       = !s3_valid_r || out_ready;
  assign q_pop    = en && q_valid;
  assign in_range = ({1'b0, q_item.idx} < (IDX_W+1)'(PALETTE_ENTRIES));

  psab_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (q_pop && !q_item.is_pixel && in_range),
    .waddr (q_item.idx[AW-1:0]),
    .wdata (q_item.data),
    .re    (q_pop && q_item.is_pixel),
    .raddr (q_item.idx[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Out-of-range index reads as transparent black
  assign top = s1_inr_r ? ram_rdata : '0;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_c[c] = 16'(top[8*c +: 8]) * 16'(top[31:24]) +
                 16'(s1_back_r[8*c +: 8]) * 16'(8'd255 - top[31:24]);
    end
  end

  // floor(s/255) = (s + 1 + (s >> 8)) >> 8, exact for s up to 255*255
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      quo_c[c] = 8'((s2_sum_r[c] + 16'd1 + (s2_sum_r[c] >> 8)) >> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= q_pop && q_item.is_pixel;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_item.is_pixel) begin
      s1_meta_r.vis  <= q_item.vis;
      s1_meta_r.x    <= q_item.x;
      s1_meta_r.y    <= q_item.y;
      s1_meta_r.last <= q_item.last;
      s1_back_r      <= q_item.data;
      s1_inr_r       <= in_range;
    end
    if (en && s1_valid_r) begin
      s2_meta_r  <= s1_meta_r;
      s2_alpha_r <= s1_back_r[31:24];
      s2_sum_r   <= sum_c;
    end
    if (en && s2_valid_r) begin
      s3_meta_r    <= s2_meta_r;
      s3_blended_r <= s2_meta_r.vis ? {s2_alpha_r, quo_c[2], quo_c[1], quo_c[0]} : '0;
    end
  end

  assign out_valid   = s3_valid_r;
  assign out_vis     = s3_meta_r.vis;
  assign out_x       = s3_meta_r.x;
  assign out_y       = s3_meta_r.y;
  assign out_blended = s3_blended_r;
  assign out_last    = s3_meta_r.last;

endmodule

`default_nettype wire

FILE: design/palette_sprite_alpha_blit.sv
// palette_sprite_alpha_blit: top level of the palettized sprite blitter.
// Depends on psab_pkg, psab_front, psab_fifo, psab_back and psab_ram.
//
// Sprite blitter with palette lookup and alpha blend. Each input transfer is
// either a palette write (tuser = 0: entry color_index gets palette_color, no
// result) or a sprite pixel (tuser = 1) in row-major order, carrying its
// palette index and the destination pixel under it. Every pixel gives exactly
// one result: its surface position, a visible flag from clipping against the
// surface, the per-channel blend (top*a + back*(255-a))/255 with the
// background alpha kept, and tlast on the final pixel of the sprite. The
// block sustains one item per clock while out_tready keeps up, set by the
// single write/read palette memory which the back end uses once per item.
// A pixel's result passes from the queue write at its transfer through the
// palette read, the blend products and the divide into the output
// register. A four-entry queue lets input transfers continue while a result
// waits for out_tready. Palette entries are undefined until written; there
// is no clearing pass. Configuration writes take effect at once and must
// only be made while the block is idle; they do not restart the sprite
// counters.
`default_nettype none

module palette_sprite_alpha_blit import psab_pkg::*; #(
  parameter int PALETTE_ENTRIES = 256,
  parameter int MAX_SPRITE_DIM  = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [71:0]          in_tdata,  // color_index, palette_color, background
  input  wire logic [0:0]           in_tuser,  // action
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [55:0]               out_tdata, // out_x, out_y, blended
  output logic [0:0]                out_tuser, // visible
  output logic                      out_tlast
);

  blit_item_t         front_item;
  blit_item_t         q_item;
  fifo_stat_t         q_stat;
  logic               in_xfer;
  logic               q_pop;
  logic               res_vis;
  logic [POS_W-1:0]   res_x, res_y;
  logic [COLOR_W-1:0] res_blended;

  // Accept whenever the queue has room
  assign in_tready = !q_stat.full;
  assign in_xfer   = in_tvalid && in_tready;

  psab_front #(
    .MAX_SPRITE_DIM (MAX_SPRITE_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .accept        (in_xfer),
    .action        (in_tuser[0]),
    .color_index   (in_tdata[7:0]),
    .palette_color (in_tdata[39:8]),
    .background    (in_tdata[71:40]),
    .item          (front_item)
  );

  psab_fifo u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_xfer),
    .push_item (front_item),
    .pop       (q_pop),
    .pop_item  (q_item),
    .stat      (q_stat)
  );

  psab_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (!q_stat.empty),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_vis     (res_vis),
    .out_x       (res_x),
    .out_y       (res_y),
    .out_blended (res_blended),
    .out_last    (out_tlast)
  );

  assign out_tdata    = {res_blended, res_y, res_x};
  assign out_tuser[0] = res_vis;

  // queue occupancy never exceeds its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("item queue over depth");

  // back end only pops a queue that holds an item
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("pop from empty item queue");

  // a clipped pixel carries zero position and color
  a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("clipped pixel with nonzero payload");

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking bench for palette_sprite_alpha_blit: palette loads and sprite pixels
// drive a cycle-free blit/blend predictor in a scoreboard class that checks each result.
// Depends on psab_pkg and the palette_sprite_alpha_blit top level only.
`timescale 1ns / 100ps

module testbench;
  import psab_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 600000;
  // Time for the queue plus palette read, products and divide to empty.
  // Palette loads leave no result, so settle this long before a register write.
  localparam int SETTLE_CYCLES = 12;
  localparam int SPRITE_LIMIT  = 256;
  localparam int RANDOM_ITEMS  = 900;

  // One expected pixel result, fields as they come out of the block
  typedef struct packed {
    logic        vis;
    logic [11:0] x;
    logic [11:0] y;
    logic [31:0] px;
    logic        last;
  } pix_result_t;

  // Scoreboard: mirrors palette, sprite counters and registers; computes the
  // placement, clip and blend of each pixel transfer and holds the results in order.
  class blit_scoreboard;
    logic [31:0]  palette [256];
    int unsigned  col_pos, row_pos;
    int unsigned  surf_w, surf_h, spr_w, spr_h;
    int           org_x, org_y;
    pix_result_t  pending_pixels [$];
    int           errors, n_checked, n_visible, n_ends, n_loads, n_pixels;

    function new();
      col_pos = 0;
      row_pos = 0;
      surf_w  = 640;
      surf_h  = 480;
      spr_w   = 8;
      spr_h   = 8;
      org_x   = 0;
      org_y   = 0;
    endfunction

    function void set_reg(cfg_reg_t r, logic [CFG_W-1:0] v);
      case (r)
        CFG_SURFACE_WIDTH:  surf_w = v;
        CFG_SURFACE_HEIGHT: surf_h = v;
        CFG_SPRITE_WIDTH:   spr_w  = v[8:0];
        CFG_SPRITE_HEIGHT:  spr_h  = v[8:0];
        CFG_DEST_LEFT:      org_x  = $signed(v);
        CFG_DEST_TOP:       org_y  = $signed(v);
        default: ;
      endcase
    endfunction

    function int unsigned fit(int unsigned v, int unsigned lo, int unsigned hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // (top*a + back*(255-a))/255 on one 8-bit channel
    function logic [7:0] mix(logic [7:0] t, logic [7:0] a, logic [7:0] b);
      int unsigned sum;
      sum = t * a + b * (255 - a);
      return 8'(sum / 255);
    endfunction

    function void take_item(logic act, logic [7:0] idx, logic [31:0] col, logic [31:0] bg);
      int unsigned w, h;
      int          x, y;
      logic [31:0] top;
      logic [7:0]  a;
      bit          col_end, row_end;
      pix_result_t want;
      if (act == ACT_PALETTE) begin
        palette[idx] = col;
        n_loads++;
        return;
      end
      n_pixels++;
      w   = fit(spr_w, 1, SPRITE_LIMIT);
      h   = fit(spr_h, 1, SPRITE_LIMIT);
      top = palette[idx];
      a   = top[31:24];
      x   = org_x + int'(col_pos);
      y   = org_y + int'(row_pos);
      want.vis = x >= 0 && y >= 0 &&
                 x < int'(fit(surf_w, 0, MAX_SURFACE_DIM)) &&
                 y < int'(fit(surf_h, 0, MAX_SURFACE_DIM));
      // a counter already at or past a shrunken size wraps on this step
      col_end   = col_pos + 1 >= w;
      row_end   = row_pos + 1 >= h;
      want.last = col_end && row_end;
      if (col_end) begin
        col_pos = 0;
        row_pos = row_end ? 0 : row_pos + 1;
      end else begin
        col_pos = col_pos + 1;
      end
      want.x  = want.vis ? 12'(x) : '0;
      want.y  = want.vis ? 12'(y) : '0;
      want.px = want.vis ? {bg[31:24], mix(top[23:16], a, bg[23:16]),
                            mix(top[15:8], a, bg[15:8]), mix(top[7:0], a, bg[7:0])} : '0;
      pending_pixels.push_back(want);
    endfunction

    function void field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %08h, actual %08h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pixel(logic vis, logic [11:0] x, logic [11:0] y, logic [31:0] px,
                              logic last);
      pix_result_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual vis=%0b x=%0d y=%0d px=%08h last=%0b",
                 $time, vis, x, y, px, last);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      n_checked++;
      if (want.vis)  n_visible++;
      if (want.last) n_ends++;
      field("visible", 32'(want.vis), 32'(vis));
      field("out_x", 32'(want.x), 32'(x));
      field("out_y", 32'(want.y), 32'(y));
      field("blended", want.px, px);
      field("last", 32'(want.last), 32'(last));
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  cfg_reg_t    cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // color_index, palette_color, background
  logic [0:0]  in_tuser;   // action
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // out_x, out_y, blended
  logic [0:0]  out_tuser;  // visible
  logic        out_tlast;

  blit_scoreboard sb;
  int          cycle_count = 0;
  int          in_count = 0;       // accepted input transfers
  int          random_sent = 0;
  int          n_settings = 1;     // reset values count as the first setting
  bit          quiet = 1'b0;       // no gaps on either side while set
  bit          long_hold_done = 1'b0;
  bit          idx_loaded [256];   // entries that may be looked up
  logic [7:0]  loaded_list [$];

  palette_sprite_alpha_blit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, CYCLE_LIMIT, sb.pending());
      $display("FAIL palette_sprite_alpha_blit");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // One input transfer. Valid stays high between back-to-back items, so only
  // one assignment to in_tvalid lands in any time step.
  task automatic send_item(input logic act, input logic [7:0] idx, input logic [31:0] col,
                           input logic [31:0] bg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {bg, col, idx};
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.take_item(act, idx, col, bg);
    in_count++;
    if (act == ACT_PALETTE && !idx_loaded[idx]) begin
      idx_loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
  endtask

  // Random traffic: some palette loads, mostly pixels that look up loaded entries.
  task automatic send_random_item();
    logic [7:0]  idx;
    logic [31:0] col, bg;
    col = $urandom;
    bg  = $urandom;
    case ($urandom_range(0, 7))
      0: bg = '0;
      1: bg = '1;
      default: ;
    endcase
    if (loaded_list.size() == 0 || $urandom_range(0, 99) < 15) begin
      idx = $urandom_range(0, 255);
      case ($urandom_range(0, 3))
        0: col[31:24] = 8'h00;
        1: col[31:24] = 8'hFF;
        default: ;
      endcase
      send_item(ACT_PALETTE, idx, col, bg);
    end else begin
      idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
      send_item(ACT_PIXEL, idx, col, bg);
    end
  endtask

  task automatic run_random(input int n);
    repeat (n) send_random_item();
    random_sent += n;
  endtask

  // Sender pause: every expected result in, then the pipeline settles.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int v);
    cfg_we    <= 1'b1;
    cfg_index <= r;
    cfg_wdata <= CFG_W'(v);
    sb.set_reg(r, CFG_W'(v));
    @(posedge clk);
  endtask

  // New register setting, only while idle; the sprite counters carry over.
  task automatic set_blit(input int sw, input int sh, input int pw, input int ph,
                          input int dl, input int dt);
    drain();
    write_reg(CFG_SURFACE_WIDTH, sw);
    write_reg(CFG_SURFACE_HEIGHT, sh);
    write_reg(CFG_SPRITE_WIDTH, pw);
    write_reg(CFG_SPRITE_HEIGHT, ph);
    write_reg(CFG_DEST_LEFT, dl);
    write_reg(CFG_DEST_TOP, dt);
    cfg_we <= 1'b0;
    n_settings++;
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Result side: checks each transfer, stalls at random, and once holds off
  // long enough for the internal queue to fill and back up the input.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1)
        sb.check_pixel(out_tuser[0], out_tdata[11:0], out_tdata[23:12], out_tdata[55:24],
                       out_tlast);
      if (!long_hold_done && in_count >= 150) begin
        long_hold_done = 1'b1;
        stall_left = 150;
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    sb = new();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_SURFACE_WIDTH;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= ACT_PALETTE;
    in_tdata  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset registers (640x480 surface, 8x8 sprite at the origin):
    // transparent, opaque, half alpha, index extremes, reload of an entry.
    send_item(ACT_PALETTE, 8'h00, 32'h0000_0000, 32'h0);
    send_item(ACT_PALETTE, 8'hFF, 32'hFFFF_FFFF, 32'h0);
    send_item(ACT_PALETTE, 8'h55, 32'h80AA_55FF, 32'h0);
    send_item(ACT_PALETTE, 8'hAA, 32'h7F55_AA00, 32'hFFFF_FFFF);
    send_item(ACT_PALETTE, 8'h01, 32'hFF12_3456, 32'h0);
    send_item(ACT_PIXEL, 8'h00, 32'h0, 32'h0000_0000);
    send_item(ACT_PIXEL, 8'h00, 32'h0, 32'hFFFF_FFFF);
    send_item(ACT_PIXEL, 8'hFF, 32'h0, 32'h0000_0000);
    send_item(ACT_PIXEL, 8'hFF, 32'h0, 32'hFFFF_FFFF);
    send_item(ACT_PIXEL, 8'h55, 32'h0, 32'h1234_5678);
    send_item(ACT_PIXEL, 8'h55, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ACT_PIXEL, 8'hAA, 32'h0, 32'h0000_0000);
    send_item(ACT_PIXEL, 8'hAA, 32'h0, 32'hA5A5_A5A5);
    send_item(ACT_PIXEL, 8'h01, 32'h0, 32'h5A5A_5A5A);
    send_item(ACT_PALETTE, 8'h55, 32'h01FF_FFFF, 32'h0);
    send_item(ACT_PIXEL, 8'h55, 32'h0, 32'h8000_0000);
    send_item(ACT_PIXEL, 8'h01, 32'h0, 32'hFF00_FF00);

    run_random(60);

    // Extremes: oversized surface (clips at 4096), widest sprite (511 clamps
    // to 256), one row at the far corner so the right part is clipped.
    set_blit(8191, 8191, 511, 1, 3900, 4095);
    run_random(300);
    // Empty surface: nothing visible; zero sprite size clamps to 1x1.
    set_blit(0, 0, 0, 0, -4096, -4096);
    run_random(40);
    // One-pixel surface, one-wide tall sprite left unfinished on purpose.
    set_blit(1, 1, 1, 511, 0, -20);
    run_random(60);
    // Sprite shrinks while its row counter is past the new height.
    set_blit(4096, 4096, 3, 2, 4093, 4094);
    run_random(40);

    while (random_sent < RANDOM_ITEMS) begin
      set_blit(($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48),
               ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 48),
               ($urandom_range(0, 11) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 10),
               ($urandom_range(0, 11) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 10),
               ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                           : int'($urandom_range(0, 40)) - 12,
               ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191)) - 4096
                                           : int'($urandom_range(0, 40)) - 12);
      run_random($urandom_range(40, 90));
    end

    // Wind down: everything expected has come, then a wait for strays.
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d input transfers (%0d palette loads, %0d pixels) over %0d register settings.",
             in_count, sb.n_loads, sb.n_pixels, n_settings);
    $display("Checked %0d results: %0d visible, %0d sprite ends, %0d errors.",
             sb.n_checked, sb.n_visible, sb.n_ends, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS palette_sprite_alpha_blit");
    end else begin
      $display("FAIL palette_sprite_alpha_blit");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/psab_pkg.sv
design/psab_ram.sv
design/psab_front.sv
design/psab_fifo.sv
design/psab_back.sv
design/palette_sprite_alpha_blit.sv
sim/testbench.sv
